@@ src/assert_macros.svh @@
// Assertion helpers for the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, off during reset
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion, checked during reset too
`define ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ src/bht_pkg.sv @@
`default_nettype none
package bht_pkg;
   localparam logic [1:0] CMD_INSERT = 2'd0;
   localparam logic [1:0] CMD_SEARCH = 2'd1;
   localparam logic [1:0] CMD_DELETE = 2'd2;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_NOTFOUND = 2'd1;
   localparam logic [1:0] ST_FULL     = 2'd2;

   localparam int KEY_W = 32;
   localparam int RID_W = 31;

   typedef logic [KEY_W-1:0] key_type;
   typedef logic [RID_W-1:0] rid_type;
endpackage
`default_nettype wire

@@ src/bucket_hash_table_with_overflow.sv @@
// Bucketed hash table of (key, record id) pairs with overflow pages. One request at a
// time: after reset a clearing pass empties the page table, then each request passes
// the key-modulo unit (a reciprocal multiply, one 16-bit key half a cycle through one
// shared multiplier) and visits pages: insert reads each page's count, search and
// delete scan its slots (one slot compare a cycle through the slot memory's single read
// port), and a delete moves the page's last record into the hit slot. The response is
// posted once the output register is free; the next request is taken in the cycle after.
// A finished response waits in an output register while the next request is taken.
`default_nettype none
module bucket_hash_table_with_overflow #(
   parameter int NUM_BUCKETS    = 16,
   parameter int SLOTS_PER_PAGE = 8,
   parameter int NUM_PAGES      = 64
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_stall,
   input  wire logic [1:0]      req_cmd,
   input  wire bht_pkg::key_type req_key,
   input  wire bht_pkg::rid_type req_record_id,
   output logic                 rsp_valid,
   input  wire logic            rsp_stall,
   output logic [1:0]           rsp_status,
   output bht_pkg::rid_type     rsp_found_id
);
   import bht_pkg::*;

   localparam int RW = $clog2(NUM_BUCKETS) + 1;
   localparam int PW = $clog2(NUM_PAGES);
   localparam int UW = $clog2(NUM_PAGES + 1);
   localparam int CW = $clog2(SLOTS_PER_PAGE + 1);
   localparam int TOTAL = NUM_PAGES * SLOTS_PER_PAGE;
   localparam int AW = $clog2(TOTAL);
   localparam int USED_RESET = (NUM_BUCKETS < NUM_PAGES) ? NUM_BUCKETS : NUM_PAGES;

   localparam logic [3:0] S_CLEAR = 4'd0;
   localparam logic [3:0] S_IDLE  = 4'd1;
   localparam logic [3:0] S_MOD   = 4'd2;
   localparam logic [3:0] S_PREAD = 4'd3;
   localparam logic [3:0] S_PGOT  = 4'd4;
   localparam logic [3:0] S_SCAN  = 4'd5;
   localparam logic [3:0] S_DREAD = 4'd6;
   localparam logic [3:0] S_DWAIT = 4'd7;
   localparam logic [3:0] S_DONE  = 4'd8;

   // memories
   key_type       slot_key_mem [TOTAL];
   rid_type       slot_rid_mem [TOTAL];
   logic [CW-1:0] pg_cnt_mem [NUM_PAGES];
   logic [PW-1:0] pg_nxt_mem [NUM_PAGES];
   logic          pg_hasn_mem [NUM_PAGES];

   key_type       slot_key_q;
   rid_type       slot_rid_q;
   logic [CW-1:0] pg_cnt_q;
   logic [PW-1:0] pg_nxt_q;
   logic          pg_hasn_q;

   logic          slot_we;
   logic [AW-1:0] slot_waddr, slot_raddr;
   key_type       slot_wkey;
   rid_type       slot_wrid;
   logic          pg_we;
   logic [PW-1:0] pg_waddr;
   logic [CW-1:0] pg_wcnt;
   logic [PW-1:0] pg_wnxt;
   logic          pg_whasn;

   logic [3:0]    state_ff, state_in;
   logic [1:0]    cmd_ff, cmd_in;
   key_type       key_ff, key_in;
   rid_type       rid_ff, rid_in;
   logic [PW-1:0] p_ff, p_in;
   logic [CW-1:0] i_ff, i_in;
   logic          cmp_v_ff, cmp_v_in;
   logic [CW-1:0] cmp_i_ff, cmp_i_in;
   logic          hit_ff, hit_in;
   logic [CW-1:0] hit_i_ff, hit_i_in;
   rid_type       hit_rid_ff, hit_rid_in;
   logic [UW-1:0] used_ff, used_in;
   logic [PW-1:0] clr_ff, clr_in;
   logic [1:0]    stat_ff, stat_in;
   rid_type       fid_ff, fid_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [1:0]    rsp_status_ff, rsp_status_in;
   rid_type       rsp_fid_ff, rsp_fid_in;

   logic          mod_start, mod_done;
   logic [RW-1:0] mod_rem;
   logic [AW-1:0] base;
   logic          match;

   bht_mod #(.NUM_BUCKETS(NUM_BUCKETS), .RW(RW)) u_mod (
      .clock (clock),
      .reset (reset),
      .start (mod_start),
      .key   (key_ff),
      .done  (mod_done),
      .rem   (mod_rem)
   );

   always_ff @(posedge clock) begin
      if (slot_we) begin
         slot_key_mem[slot_waddr] <= slot_wkey;
         slot_rid_mem[slot_waddr] <= slot_wrid;
      end
      slot_key_q <= slot_key_mem[slot_raddr];
      slot_rid_q <= slot_rid_mem[slot_raddr];
   end

   always_ff @(posedge clock) begin
      if (pg_we) begin
         pg_cnt_mem[pg_waddr]  <= pg_wcnt;
         pg_nxt_mem[pg_waddr]  <= pg_wnxt;
         pg_hasn_mem[pg_waddr] <= pg_whasn;
      end
      pg_cnt_q  <= pg_cnt_mem[p_ff];
      pg_nxt_q  <= pg_nxt_mem[p_ff];
      pg_hasn_q <= pg_hasn_mem[p_ff];
   end

   assign base  = AW'(p_ff) * AW'(SLOTS_PER_PAGE);
   assign match = (slot_key_q == key_ff) && ((cmd_ff == CMD_SEARCH) || (slot_rid_q == rid_ff));

   always_comb begin
      state_in   = state_ff;
      cmd_in     = cmd_ff;
      key_in     = key_ff;
      rid_in     = rid_ff;
      p_in       = p_ff;
      i_in       = i_ff;
      cmp_v_in   = 1'b0;
      cmp_i_in   = cmp_i_ff;
      hit_in     = hit_ff;
      hit_i_in   = hit_i_ff;
      hit_rid_in = hit_rid_ff;
      used_in    = used_ff;
      clr_in     = clr_ff;
      stat_in    = stat_ff;
      fid_in     = fid_ff;
      mod_start  = 1'b0;
      slot_we    = 1'b0;
      slot_waddr = base + AW'(i_ff);
      slot_raddr = base + AW'(i_ff);
      slot_wkey  = key_ff;
      slot_wrid  = rid_ff;
      pg_we      = 1'b0;
      pg_waddr   = p_ff;
      pg_wcnt    = pg_cnt_q;
      pg_wnxt    = pg_nxt_q;
      pg_whasn   = pg_hasn_q;

      unique case (state_ff)
         S_CLEAR: begin
            pg_we    = 1'b1;
            pg_waddr = clr_ff;
            pg_wcnt  = '0;
            pg_wnxt  = '0;
            pg_whasn = 1'b0;
            clr_in   = clr_ff + PW'(1);
            if (clr_ff == PW'(NUM_PAGES - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd_in    = req_cmd;
               key_in    = req_key;
               rid_in    = req_record_id;
               state_in  = S_MOD;
               mod_start = 1'b1;
            end
         end
         S_MOD: begin
            if (mod_done) begin
               fid_in = '0;
               if ((32'(mod_rem) >= 32'(NUM_PAGES)) || (cmd_ff != CMD_INSERT &&
                   cmd_ff != CMD_SEARCH && cmd_ff != CMD_DELETE)) begin
                  stat_in  = (cmd_ff == CMD_INSERT) ? ST_FULL : ST_NOTFOUND;
                  state_in = S_DONE;
               end else begin
                  p_in     = PW'(mod_rem);
                  state_in = S_PREAD;
               end
            end
         end
         S_PREAD: begin
            state_in = S_PGOT;
         end
         S_PGOT: begin
            i_in   = '0;
            hit_in = 1'b0;
            if (cmd_ff == CMD_INSERT) begin
               if (pg_cnt_q < CW'(SLOTS_PER_PAGE)) begin
                  slot_we    = 1'b1;
                  slot_waddr = base + AW'(pg_cnt_q);
                  pg_we      = 1'b1;
                  pg_wcnt    = pg_cnt_q + CW'(1);
                  // page just filled: link a fresh page if the pool has one
                  if ((pg_cnt_q == CW'(SLOTS_PER_PAGE - 1)) && !pg_hasn_q &&
                      (used_ff < UW'(NUM_PAGES))) begin
                     pg_wnxt  = PW'(used_ff);
                     pg_whasn = 1'b1;
                     used_in  = used_ff + UW'(1);
                  end
                  stat_in  = ST_OK;
                  state_in = S_DONE;
               end else if (!pg_hasn_q) begin
                  stat_in  = ST_FULL;
                  state_in = S_DONE;
               end else begin
                  p_in     = pg_nxt_q;
                  state_in = S_PREAD;
               end
            end else begin
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            if (i_ff < pg_cnt_q) begin
               cmp_v_in = 1'b1;
               cmp_i_in = i_ff;
               i_in     = i_ff + CW'(1);
            end
            if (cmp_v_ff && match) begin
               hit_in     = 1'b1;
               hit_i_in   = cmp_i_ff;
               hit_rid_in = slot_rid_q;
            end
            if ((i_ff == pg_cnt_q) && !cmp_v_ff) begin
               if (hit_ff) begin
                  if (cmd_ff == CMD_SEARCH) begin
                     stat_in  = ST_OK;
                     fid_in   = hit_rid_ff;
                     state_in = S_DONE;
                  end else begin
                     state_in = S_DREAD;
                  end
               end else if (!pg_hasn_q) begin
                  stat_in  = ST_NOTFOUND;
                  state_in = S_DONE;
               end else begin
                  p_in     = pg_nxt_q;
                  state_in = S_PREAD;
               end
            end
         end
         S_DREAD: begin
            // fetch the page's last record
            slot_raddr = base + AW'(pg_cnt_q - CW'(1));
            state_in   = S_DWAIT;
         end
         S_DWAIT: begin
            slot_we    = 1'b1;
            slot_waddr = base + AW'(hit_i_ff);
            slot_wkey  = slot_key_q;
            slot_wrid  = slot_rid_q;
            pg_we      = 1'b1;
            pg_wcnt    = pg_cnt_q - CW'(1);
            stat_in    = ST_OK;
            state_in   = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_fid_in    = rsp_fid_ff;
      if ((state_ff == S_DONE) && (!rsp_valid_ff || !rsp_stall)) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = stat_ff;
         rsp_fid_in    = fid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         used_ff      <= UW'(USED_RESET);
         rsp_valid_ff <= 1'b0;
         cmp_v_ff     <= 1'b0;
         hit_ff       <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         used_ff      <= used_in;
         rsp_valid_ff <= rsp_valid_in;
         cmp_v_ff     <= cmp_v_in;
         hit_ff       <= hit_in;
      end
      cmd_ff        <= cmd_in;
      key_ff        <= key_in;
      rid_ff        <= rid_in;
      p_ff          <= p_in;
      i_ff          <= i_in;
      cmp_i_ff      <= cmp_i_in;
      hit_i_ff      <= hit_i_in;
      hit_rid_ff    <= hit_rid_in;
      stat_ff       <= stat_in;
      fid_ff        <= fid_in;
      rsp_status_ff <= rsp_status_in;
      rsp_fid_ff    <= rsp_fid_in;
   end

   assign req_stall    = (state_ff != S_IDLE);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_status   = rsp_status_ff;
   assign rsp_found_id = rsp_fid_ff;

`include "assert_macros.svh"
   `ASSERT_CLK(a_used_bound, clock, reset, used_ff <= UW'(NUM_PAGES), "page pool overrun")
   `ASSERT_CLK(a_mod_done, clock, reset, mod_done |-> ($past(state_ff) == S_MOD), "stray modulo done")
   `ASSERT_CLK(a_slot_we, clock, reset, slot_we |-> (state_ff == S_PGOT || state_ff == S_DWAIT), "slot write outside update")
   `ASSERT_CLK(a_rsp_load, clock, reset, $rose(rsp_valid_ff) |-> ($past(state_ff) == S_DONE), "response without completion")
endmodule
`default_nettype wire

@@ src/bht_mod.sv @@
`default_nettype none
module bht_mod #(
   parameter int NUM_BUCKETS = 16,
   parameter int RW = $clog2(NUM_BUCKETS) + 1
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            start,
   input  wire bht_pkg::key_type key,
   output logic                 done,
   output logic [RW-1:0]        rem
);
   import bht_pkg::*;

   // floor(2^(32+L) / N) + 1 makes (key * MAGIC) >> (32+L) the exact quotient
   // for every 32-bit key
   localparam int L = $clog2(NUM_BUCKETS);
   localparam logic [63:0] MAGIC_W = ((64'd1 << (32 + L)) / 64'(NUM_BUCKETS)) + 64'd1;
   localparam logic [33:0] MAGIC = MAGIC_W[33:0];

   localparam logic [1:0] M_IDLE = 2'd0;
   localparam logic [1:0] M_LO   = 2'd1;
   localparam logic [1:0] M_HI   = 2'd2;
   localparam logic [1:0] M_REM  = 2'd3;

   logic [1:0]    step_ff, step_in;
   logic          done_ff, done_in;
   logic [65:0]   acc_ff, acc_in;
   logic [RW-1:0] r_ff, r_in;
   logic [15:0]   half;
   logic [49:0]   prod;
   logic [RW-1:0] q_lo;

   // one shared multiplier, one 16-bit key half a cycle
   always_comb begin
      half = (step_ff == M_HI) ? key[KEY_W-1:16] : key[15:0];
      prod = {34'b0, half} * {16'b0, MAGIC};
   end

   // only the low bits of the quotient matter for the remainder
   assign q_lo = acc_ff[32 + L +: RW];

   always_comb begin
      step_in = step_ff;
      done_in = 1'b0;
      acc_in  = acc_ff;
      r_in    = r_ff;
      unique case (step_ff)
         M_IDLE: begin
            if (start) begin
               step_in = M_LO;
            end
         end
         M_LO: begin
            acc_in  = {16'b0, prod};
            step_in = M_HI;
         end
         M_HI: begin
            acc_in  = acc_ff + {prod, 16'b0};
            step_in = M_REM;
         end
         M_REM: begin
            r_in    = key[RW-1:0] - RW'(q_lo * RW'(NUM_BUCKETS));
            done_in = 1'b1;
            step_in = M_IDLE;
         end
         default: begin
            step_in = M_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= M_IDLE;
         done_ff <= 1'b0;
      end else begin
         step_ff <= step_in;
         done_ff <= done_in;
      end
      acc_ff <= acc_in;
      r_ff   <= r_in;
   end

   assign done = done_ff;
   assign rem  = r_ff;
endmodule
`default_nettype wire

@@ tb/sv/bht_checker.sv @@
`timescale 1ns / 1ps
module bht_checker #(
   parameter int NUM_BUCKETS    = 16,
   parameter int SLOTS_PER_PAGE = 8,
   parameter int NUM_PAGES      = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_stall,
   input  logic [1:0]       req_cmd,
   input  bht_pkg::key_type req_key,
   input  bht_pkg::rid_type req_record_id,
   input  logic             rsp_valid,
   input  logic             rsp_stall,
   input  logic [1:0]       rsp_status,
   input  bht_pkg::rid_type rsp_found_id,
   output int               fail_count,
   output int               pending,
   output int               n_requests,
   output int               n_hits,
   output int               n_full
);
   import bht_pkg::*;

   typedef struct packed {
      logic [1:0] status;
      rid_type    found_id;
   } answer_t;

   localparam int TOTAL = NUM_PAGES * SLOTS_PER_PAGE;

   key_type tbl_key[TOTAL];
   rid_type tbl_rid[TOTAL];
   int      pg_count[NUM_PAGES];
   int      pg_next[NUM_PAGES];
   bit      pg_linked[NUM_PAGES];
   int      pg_used;
   answer_t answers_due[$];

   function automatic int last_match(int p, key_type k, rid_type r, bit need_rid);
      int hit;
      hit = -1;
      for (int i = 0; i < pg_count[p]; i++)
         if (tbl_key[p*SLOTS_PER_PAGE+i] == k && (!need_rid || tbl_rid[p*SLOTS_PER_PAGE+i] == r))
            hit = i;
      return hit;
   endfunction

   function automatic answer_t table_apply(logic [1:0] cmd, key_type k, rid_type r);
      answer_t a;
      int p, hit, s;
      a.status = (cmd == CMD_INSERT) ? ST_FULL : ST_NOTFOUND;
      a.found_id = '0;
      p = k % NUM_BUCKETS;
      if (p >= NUM_PAGES || !(cmd inside {CMD_INSERT, CMD_SEARCH, CMD_DELETE}))
         return a;
      for (int step = 0; step < NUM_PAGES; step++) begin
         if (cmd == CMD_INSERT) begin
            if (pg_count[p] < SLOTS_PER_PAGE) begin
               s = p*SLOTS_PER_PAGE + pg_count[p];
               tbl_key[s] = k;
               tbl_rid[s] = r;
               pg_count[p]++;
               if (pg_count[p] == SLOTS_PER_PAGE && !pg_linked[p] && pg_used < NUM_PAGES) begin
                  pg_count[pg_used] = 0;
                  pg_linked[pg_used] = 0;
                  pg_next[p] = pg_used;
                  pg_linked[p] = 1;
                  pg_used++;
               end
               a.status = ST_OK;
               return a;
            end
         end else begin
            hit = last_match(p, k, r, cmd == CMD_DELETE);
            if (hit >= 0) begin
               a.status = ST_OK;
               if (cmd == CMD_SEARCH) begin
                  a.found_id = tbl_rid[p*SLOTS_PER_PAGE+hit];
               end else begin
                  s = p*SLOTS_PER_PAGE + pg_count[p] - 1;
                  tbl_key[p*SLOTS_PER_PAGE+hit] = tbl_key[s];
                  tbl_rid[p*SLOTS_PER_PAGE+hit] = tbl_rid[s];
                  pg_count[p]--;
               end
               return a;
            end
         end
         if (!pg_linked[p] || pg_next[p] >= NUM_PAGES)
            return a;
         p = pg_next[p];
      end
      return a;
   endfunction

   assign pending = answers_due.size();

   always @(posedge clock) begin
      answer_t want;
      if (reset) begin
         for (int i = 0; i < NUM_PAGES; i++) begin
            pg_count[i] = 0;
            pg_linked[i] = 0;
            pg_next[i] = 0;
         end
         pg_used = (NUM_BUCKETS < NUM_PAGES) ? NUM_BUCKETS : NUM_PAGES;
         answers_due.delete();
         fail_count <= 0;
         n_requests <= 0;
         n_hits <= 0;
         n_full <= 0;
      end else begin
         // check before predicting: a result cannot belong to this cycle's request
         if (rsp_valid && !rsp_stall) begin
            if (answers_due.size() == 0) begin
               if (fail_count < 10)
                  $display("%0t: unexpected response status=%0d id=%0d",
                           $realtime, rsp_status, rsp_found_id);
               fail_count <= fail_count + 1;
            end else begin
               want = answers_due.pop_front();
               if (want.status != rsp_status || want.found_id != rsp_found_id) begin
                  if (fail_count < 10)
                     $display("%0t: mismatch status exp %0d got %0d, id exp %0d got %0d",
                              $realtime, want.status, rsp_status, want.found_id,
                              rsp_found_id);
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (req_valid && !req_stall) begin
            want = table_apply(req_cmd, req_key, req_record_id);
            answers_due.push_back(want);
            n_requests <= n_requests + 1;
            if (req_cmd == CMD_SEARCH && want.status == ST_OK) n_hits <= n_hits + 1;
            if (want.status == ST_FULL) n_full <= n_full + 1;
         end
      end
   end
endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps
module tb;
   import bht_pkg::*;

   logic       clock = 0;
   logic       reset = 1;
   logic       req_valid = 0;
   logic       req_stall;
   logic [1:0] req_cmd = CMD_INSERT;
   key_type    req_key = '0;
   rid_type    req_record_id = '0;
   logic       rsp_valid;
   logic       rsp_stall = 0;
   logic [1:0] rsp_status;
   rid_type    rsp_found_id;
   int         fail_count, pending, n_requests, n_hits, n_full;
   bit         hold_rsp = 0;
   bit         stim_done = 0;

   typedef struct packed {
      logic [1:0] cmd;
      key_type    key;
      rid_type    rid;
   } request_t;

   request_t   stored[$];
   request_t   plan[$];

   always #4 clock = ~clock;

   bucket_hash_table_with_overflow dut (.*);

   bht_checker chk (.*);

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   task automatic send(request_t q);
      req_valid     <= 1;
      req_cmd       <= q.cmd;
      req_key       <= q.key;
      req_record_id <= q.rid;
      do @(posedge clock); while (req_stall);
      if (q.cmd == CMD_INSERT) stored.push_back(q);
      if (q.cmd == CMD_DELETE) foreach (stored[i])
         if (stored[i].key == q.key && stored[i].rid == q.rid) begin
            stored.delete(i);
            break;
         end
   endtask

   task automatic send_gapped(request_t q);
      int g;
      send(q);
      g = gap_len();
      if (g > 0) begin
         req_valid <= 0;
         repeat (g) @(posedge clock);
      end
   endtask

   function automatic request_t pick_random();
      request_t q;
      int r, idx;
      // bias keys toward a few buckets so chains grow and the pool runs dry
      r = $urandom_range(0, 99);
      q.rid = 31'($urandom_range(0, 63));
      if ($urandom_range(0, 3) == 0) q.rid = 31'($urandom >> 1);
      if (r < 10) q.key = $urandom;
      else q.key = ($urandom_range(0, 40) << 4) | $urandom_range(0, 3);
      if ($urandom_range(0, 9) == 0) q.key = q.key | 32'hFFFF_FF00;
      r = $urandom_range(0, 99);
      if (r < 45) q.cmd = CMD_INSERT;
      else if (r < 72) q.cmd = CMD_SEARCH;
      else if (r < 98) q.cmd = CMD_DELETE;
      else q.cmd = 2'd3;
      if (q.cmd != CMD_INSERT && stored.size() > 0 && $urandom_range(0, 3) != 0) begin
         idx = $urandom_range(0, stored.size() - 1);
         q.key = stored[idx].key;
         if (q.cmd == CMD_DELETE) q.rid = stored[idx].rid;
      end
      return q;
   endfunction

   // receiver side: random stalls, plus one long hold-off
   always @(posedge clock) begin
      int g;
      if (reset || stim_done) begin
         rsp_stall <= 0;
      end else if (hold_rsp) begin
         rsp_stall <= 1;
      end else begin
         g = gap_len();
         rsp_stall <= (g > 0 && $urandom_range(0, 1));
      end
   end

   initial begin
      #50_000_000;
      $display("FAILURE");
      $finish;
   end

   initial begin
      request_t q;
      int drain;
      repeat (8) @(posedge clock);
      reset <= 0;
      // directed: extremes, every command, unused command, full chains
      plan.push_back('{CMD_SEARCH, 32'd5, 31'd0});
      plan.push_back('{CMD_DELETE, 32'd5, 31'd0});
      plan.push_back('{CMD_INSERT, 32'hFFFF_FFFF, 31'h7FFF_FFFF});
      plan.push_back('{CMD_INSERT, 32'd0, 31'd0});
      plan.push_back('{CMD_SEARCH, 32'hFFFF_FFFF, 31'd0});
      plan.push_back('{CMD_SEARCH, 32'd0, 31'h7FFF_FFFF});
      plan.push_back('{2'd3, 32'hFFFF_FFFF, 31'h7FFF_FFFF});
      plan.push_back('{CMD_DELETE, 32'hFFFF_FFFF, 31'd1});
      plan.push_back('{CMD_DELETE, 32'hFFFF_FFFF, 31'h7FFF_FFFF});
      for (int i = 0; i < 10; i++)
         plan.push_back('{CMD_INSERT, 32'(3 + (i << 4)), 31'(100 + i)});
      plan.push_back('{CMD_INSERT, 32'd3, 31'd7});
      plan.push_back('{CMD_SEARCH, 32'd3, 31'd0});
      plan.push_back('{CMD_DELETE, 32'd19, 31'd101});
      plan.push_back('{CMD_SEARCH, 32'd147, 31'd0});
      while (plan.size() > 0) send_gapped(plan.pop_front());
      // fill and overflow one bucket while the receiver holds off
      hold_rsp = 1;
      fork
         begin
            repeat (300) @(posedge clock);
            hold_rsp = 0;
         end
      join_none
      for (int i = 0; i < 12; i++) send('{CMD_INSERT, 32'(7 + (i << 4)), 31'(i)});
      // random: exhausts the pool, then keeps deleting and searching
      for (int i = 0; i < 1700; i++) begin
         q = pick_random();
         send_gapped(q);
      end
      req_valid <= 0;
      stim_done = 1;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      drain = 0;
      while (drain < 200) begin
         @(posedge clock);
         drain++;
      end
      $display("Ran %0d requests: %0d search hits, %0d table-full answers.",
               n_requests, n_hits, n_full);
      if (fail_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end
endmodule

@@ bucket_hash_table_with_overflow.f @@
+incdir+src
src/bht_pkg.sv
src/bht_mod.sv
src/bucket_hash_table_with_overflow.sv
tb/sv/bht_checker.sv
tb/sv/tb.sv
